[design/dram_address_mapper_xor_bank_hash_assert.svh]
// Assertion macros for the DRAM address mapper.
// Included by the top level; needs no other file.
`ifndef DRAM_ADDRESS_MAPPER_XOR_BANK_HASH_ASSERT_SVH
`define DRAM_ADDRESS_MAPPER_XOR_BANK_HASH_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define DAM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dram address mapper check failed");

// Consequence must hold in the cycle after the antecedent.
`define DAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dram address mapper check failed");

`endif

[design/dam_pkg.sv]
// Shared constants, types and the low_mask helper function of the DRAM address mapper.
// Has no dependencies; every other file but the assertion header imports it.
package dam_pkg;

    localparam int ADDR_WIDTH    = 40;
    localparam int MAX_ROW_BITS  = 18;
    localparam int MAX_COL_BITS  = 11;
    localparam int MAX_BANK_BITS = 3;
    localparam int MAX_RANK_BITS = 2;

    // Row bit taps folded into each bank index bit.
    localparam int TAP_STRIDE  = 5;
    localparam int TAP_COUNT   = 3;
    localparam int BG_TAP_BASE = 2;

    // Configuration register widths.
    localparam int GANG_W = 4;
    localparam int COLW_W = 4;
    localparam int BGW_W  = 2;
    localparam int BKW_W  = 2;
    localparam int RKW_W  = 2;
    localparam int ROWW_W = 5;
    localparam int TXO_W  = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;

    // Mask generator covers the widest field.
    localparam int MASK_W     = (MAX_ROW_BITS > MAX_COL_BITS) ? MAX_ROW_BITS : MAX_COL_BITS;
    localparam int MASK_CNT_W = $clog2(MASK_W + 1);

    // Offset of the bits above gang, bank group, bank and rank.
    localparam int SHIFT_W = $clog2(MAX_COL_BITS + 2 * MAX_BANK_BITS + MAX_RANK_BITS + 1);

    // Bits that remain for the upper column part and the row.
    localparam int REST_W = MAX_COL_BITS + MAX_ROW_BITS;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GANG_BITS      = 3'd0,
        REG_COLUMN_BITS    = 3'd1,
        REG_BANKGROUP_BITS = 3'd2,
        REG_BANK_BITS      = 3'd3,
        REG_RANK_BITS      = 3'd4,
        REG_ROW_BITS       = 3'd5,
        REG_TX_OFFSET      = 3'd6,
        REG_HASH_ENABLE    = 3'd7
    } reg_index_t;

    // Field widths after clamping, as seen by the datapath.
    typedef struct packed {
        logic [GANG_W-1:0] gang;
        logic [COLW_W-1:0] colw;
        logic [BGW_W-1:0]  bgw;
        logic [BKW_W-1:0]  bkw;
        logic [RKW_W-1:0]  rkw;
        logic [ROWW_W-1:0] roww;
        logic [TXO_W-1:0]  txo;
        logic              hash;
    } cfg_t;

    // Low fields peeled off in the first split stage.
    typedef struct packed {
        logic [MAX_COL_BITS-1:0]  col_lo;
        logic [MAX_BANK_BITS-1:0] bankgroup;
        logic [MAX_BANK_BITS-1:0] bank;
        logic [MAX_RANK_BITS-1:0] rank;
        logic [REST_W-1:0]        rest;
    } split_t;

    // Unhashed coordinates.
    typedef struct packed {
        logic [MAX_BANK_BITS-1:0] bankgroup;
        logic [MAX_BANK_BITS-1:0] bank;
        logic [MAX_RANK_BITS-1:0] rank;
        logic [MAX_ROW_BITS-1:0]  row;
        logic [MAX_COL_BITS-1:0]  column;
    } coord_t;

    // Mask with the low n bits set.
    function automatic logic [MASK_W-1:0] low_mask(input logic [MASK_CNT_W-1:0] n);
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++)
        begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

endpackage

[design/dam_req_if.sv]
// Request channel: one byte address per item.
// Depends on dam_pkg.
interface dam_req_if
    import dam_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

[design/dam_resp_if.sv]
// Result channel: DRAM coordinates of one item.
// Depends on dam_pkg.
interface dam_resp_if
    import dam_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MAX_BANK_BITS-1:0] bankgroup;
    logic [MAX_BANK_BITS-1:0] bank;
    logic [MAX_RANK_BITS-1:0] rank;
    logic [MAX_ROW_BITS-1:0]  row;
    logic [MAX_COL_BITS-1:0]  column;

    modport source (output valid, output bankgroup, output bank, output rank,
                    output row, output column, input ready);
    modport sink   (input valid, input bankgroup, input bank, input rank,
                    input row, input column, output ready);
endinterface

[design/dam_shift.sv]
// First pipeline stage: drops the transaction offset bits of the address.
// Depends on dam_pkg.
module dam_shift
    import dam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADDR_WIDTH-1:0] in_address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_WIDTH-1:0] out_address
);

    logic                  valid_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [ADDR_WIDTH-1:0] addr_next;

    // The stage takes an item when empty or when its item moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign addr_next = in_address >> cfg.txo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            addr_reg <= addr_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_address = addr_reg;

endmodule

[design/dam_split.sv]
// Second and third pipeline stages: peel off gang, bank group, bank and rank,
// then the upper column bits and the row. Depends on dam_pkg.
module dam_split
    import dam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADDR_WIDTH-1:0] in_address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output coord_t                out_coord
);

    logic              lo_valid_reg;
    split_t            lo_reg;
    split_t            lo_next;
    logic              lo_ready;
    logic              hi_valid_reg;
    coord_t            hi_reg;
    coord_t            hi_next;

    logic [SHIFT_W-1:0]    off_bank;
    logic [SHIFT_W-1:0]    off_rank;
    logic [SHIFT_W-1:0]    off_rest;
    logic [ADDR_WIDTH-1:0] sh_bg;
    logic [ADDR_WIDTH-1:0] sh_bank;
    logic [ADDR_WIDTH-1:0] sh_rank;
    logic [ADDR_WIDTH-1:0] sh_rest;
    logic [MASK_W-1:0]     mask_gang;
    logic [MASK_W-1:0]     mask_bg;
    logic [MASK_W-1:0]     mask_bank;
    logic [MASK_W-1:0]     mask_rank;

    logic [COLW_W-1:0]       hi_w;
    logic [MASK_W-1:0]       mask_hi;
    logic [MASK_W-1:0]       mask_row;
    logic [REST_W-1:0]       rest_row;
    logic [MAX_COL_BITS-1:0] col_hi;

    // Low fields, each at the running offset of the ones below it.
    always_comb
    begin
        off_bank  = SHIFT_W'(cfg.gang) + SHIFT_W'(cfg.bgw);
        off_rank  = off_bank + SHIFT_W'(cfg.bkw);
        off_rest  = off_rank + SHIFT_W'(cfg.rkw);
        sh_bg     = in_address >> cfg.gang;
        sh_bank   = in_address >> off_bank;
        sh_rank   = in_address >> off_rank;
        sh_rest   = in_address >> off_rest;
        mask_gang = low_mask(MASK_CNT_W'(cfg.gang));
        mask_bg   = low_mask(MASK_CNT_W'(cfg.bgw));
        mask_bank = low_mask(MASK_CNT_W'(cfg.bkw));
        mask_rank = low_mask(MASK_CNT_W'(cfg.rkw));

        lo_next.col_lo    = in_address[MAX_COL_BITS-1:0] & mask_gang[MAX_COL_BITS-1:0];
        lo_next.bankgroup = sh_bg[MAX_BANK_BITS-1:0] & mask_bg[MAX_BANK_BITS-1:0];
        lo_next.bank      = sh_bank[MAX_BANK_BITS-1:0] & mask_bank[MAX_BANK_BITS-1:0];
        lo_next.rank      = sh_rank[MAX_RANK_BITS-1:0] & mask_rank[MAX_RANK_BITS-1:0];
        lo_next.rest      = REST_W'(sh_rest);
    end

    // Upper column bits sit below the row in the remaining bits.
    always_comb
    begin
        hi_w     = cfg.colw - COLW_W'(cfg.gang);
        mask_hi  = low_mask(MASK_CNT_W'(hi_w));
        mask_row = low_mask(MASK_CNT_W'(cfg.roww));
        rest_row = lo_reg.rest >> hi_w;
        col_hi   = lo_reg.rest[MAX_COL_BITS-1:0] & mask_hi[MAX_COL_BITS-1:0];

        hi_next.bankgroup = lo_reg.bankgroup;
        hi_next.bank      = lo_reg.bank;
        hi_next.rank      = lo_reg.rank;
        hi_next.row       = rest_row[MAX_ROW_BITS-1:0] & mask_row[MAX_ROW_BITS-1:0];
        hi_next.column    = lo_reg.col_lo | (col_hi << cfg.gang);
    end

    // Handshake between the two stages and to the next module.
    assign in_ready = !lo_valid_reg || lo_ready;
    assign lo_ready = !hi_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_valid_reg <= 1'b0;
            hi_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                lo_valid_reg <= in_valid;
            end
            if (lo_ready)
            begin
                hi_valid_reg <= lo_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lo_reg <= lo_next;
        end
        if (lo_valid_reg && lo_ready)
        begin
            hi_reg <= hi_next;
        end
    end

    assign out_valid = hi_valid_reg;
    assign out_coord = hi_reg;

endmodule

[design/dam_hash.sv]
// Last pipeline stage: when hashing is on, folds row bit parities into bank
// group and bank and holds the result for the consumer. Depends on dam_pkg.
module dam_hash
    import dam_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t in_coord,
    output logic   out_valid,
    input  logic   out_ready,
    output coord_t out_coord
);

    logic                     valid_reg;
    coord_t                   coord_reg;
    coord_t                   coord_next;
    logic [MAX_BANK_BITS-1:0] par_bg;
    logic [MAX_BANK_BITS-1:0] par_bank;
    logic [MASK_W-1:0]        mask_bg;
    logic [MASK_W-1:0]        mask_bank;

    // Parity of three row taps per index bit. Row bits above the configured
    // width are already zero, so only the fixed row width bounds the taps.
    always_comb
    begin
        par_bg   = '0;
        par_bank = '0;
        for (int i = 0; i < MAX_BANK_BITS; i++)
        begin
            for (int t = 0; t < TAP_COUNT; t++)
            begin
                if (BG_TAP_BASE + i + t * TAP_STRIDE < MAX_ROW_BITS)
                begin
                    par_bg[i] = par_bg[i] ^ in_coord.row[BG_TAP_BASE + i + t * TAP_STRIDE];
                end
                if (i + t * TAP_STRIDE < MAX_ROW_BITS)
                begin
                    par_bank[i] = par_bank[i] ^ in_coord.row[i + t * TAP_STRIDE];
                end
            end
        end
    end

    // Only the configured index bits are hashed.
    always_comb
    begin
        mask_bg    = low_mask(MASK_CNT_W'(cfg.bgw));
        mask_bank  = low_mask(MASK_CNT_W'(cfg.bkw));
        coord_next = in_coord;
        if (cfg.hash)
        begin
            coord_next.bankgroup = in_coord.bankgroup ^ (par_bg & mask_bg[MAX_BANK_BITS-1:0]);
            coord_next.bank      = in_coord.bank ^ (par_bank & mask_bank[MAX_BANK_BITS-1:0]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            coord_reg <= coord_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_coord = coord_reg;

endmodule

[design/dram_address_mapper_xor_bank_hash.sv]
// DRAM address mapper with XOR bank hashing. Every request address is turned
// into bank group, bank, rank, row and column, and a new item is taken every
// cycle while the consumer takes results: the offset shifter, the two field
// split stages and the hashing stage are separate registers, each able to
// take an item while the one ahead moves on. When the consumer stalls, ready
// falls back through the stages in the same cycle and no item is lost. The
// field widths come from eight write-only registers that must be changed only
// while no item is in flight. Depends on dam_pkg, the channel interfaces,
// dam_shift, dam_split, dam_hash and the assertion macro header.
`include "dram_address_mapper_xor_bank_hash_assert.svh"

module dram_address_mapper_xor_bank_hash
    import dam_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   write_enable,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [CFG_DATA_W-1:0]  write_data,
    dam_req_if.sink                req,
    dam_resp_if.source             resp
);

    logic [GANG_W-1:0] gang_reg;
    logic [COLW_W-1:0] colw_reg;
    logic [BGW_W-1:0]  bgw_reg;
    logic [BKW_W-1:0]  bkw_reg;
    logic [RKW_W-1:0]  rkw_reg;
    logic [ROWW_W-1:0] roww_reg;
    logic [TXO_W-1:0]  txo_reg;
    logic              hash_reg;
    cfg_t              cfg;

    logic                  sh_valid;
    logic                  sh_ready;
    logic [ADDR_WIDTH-1:0] sh_address;
    logic                  sp_valid;
    logic                  sp_ready;
    coord_t                sp_coord;
    coord_t                out_coord;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gang_reg <= GANG_W'(2);
            colw_reg <= COLW_W'(10);
            bgw_reg  <= BGW_W'(3);
            bkw_reg  <= BKW_W'(2);
            rkw_reg  <= RKW_W'(0);
            roww_reg <= ROWW_W'(16);
            txo_reg  <= TXO_W'(6);
            hash_reg <= 1'b1;
        end
        else if (write_enable)
        begin
            unique case (reg_index_t'(write_index))
                REG_GANG_BITS:      gang_reg <= write_data[GANG_W-1:0];
                REG_COLUMN_BITS:    colw_reg <= write_data[COLW_W-1:0];
                REG_BANKGROUP_BITS: bgw_reg  <= write_data[BGW_W-1:0];
                REG_BANK_BITS:      bkw_reg  <= write_data[BKW_W-1:0];
                REG_RANK_BITS:      rkw_reg  <= write_data[RKW_W-1:0];
                REG_ROW_BITS:       roww_reg <= write_data[ROWW_W-1:0];
                REG_TX_OFFSET:      txo_reg  <= write_data[TXO_W-1:0];
                REG_HASH_ENABLE:    hash_reg <= write_data[0];
                default:            hash_reg <= hash_reg;
            endcase
        end
    end

    // Clamp the widths to what the datapath carries; gang never exceeds
    // the column width.
    always_comb
    begin
        cfg.colw = (int'(colw_reg) > MAX_COL_BITS) ? COLW_W'(MAX_COL_BITS) : colw_reg;
        cfg.gang = (gang_reg > cfg.colw) ? cfg.colw : gang_reg;
        cfg.bgw  = (int'(bgw_reg) > MAX_BANK_BITS) ? BGW_W'(MAX_BANK_BITS) : bgw_reg;
        cfg.bkw  = (int'(bkw_reg) > MAX_BANK_BITS) ? BKW_W'(MAX_BANK_BITS) : bkw_reg;
        cfg.rkw  = (int'(rkw_reg) > MAX_RANK_BITS) ? RKW_W'(MAX_RANK_BITS) : rkw_reg;
        cfg.roww = (int'(roww_reg) > MAX_ROW_BITS) ? ROWW_W'(MAX_ROW_BITS) : roww_reg;
        cfg.txo  = txo_reg;
        cfg.hash = hash_reg;
    end

    dam_shift u_shift (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_address  (req.address),
        .out_valid   (sh_valid),
        .out_ready   (sh_ready),
        .out_address (sh_address)
    );

    dam_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (sh_valid),
        .in_ready   (sh_ready),
        .in_address (sh_address),
        .out_valid  (sp_valid),
        .out_ready  (sp_ready),
        .out_coord  (sp_coord)
    );

    dam_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (sp_valid),
        .in_ready  (sp_ready),
        .in_coord  (sp_coord),
        .out_valid (resp.valid),
        .out_ready (resp.ready),
        .out_coord (out_coord)
    );

    assign resp.bankgroup = out_coord.bankgroup;
    assign resp.bank      = out_coord.bank;
    assign resp.rank      = out_coord.rank;
    assign resp.row       = out_coord.row;
    assign resp.column    = out_coord.column;

    // Backpressure only reaches the input when every stage holds an item.
    `DAM_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !req.ready, sh_valid && sp_valid && resp.valid)
    // Row and rank never carry bits above their configured widths.
    `DAM_ASSERT_NOW(a_row_width, clk, rst_n, resp.valid, (int'(resp.row) >> cfg.roww) == 0)
    `DAM_ASSERT_NOW(a_rank_width, clk, rst_n, resp.valid, (int'(resp.rank) >> cfg.rkw) == 0)
    // An accepted item is in the first stage in the next cycle.
    `DAM_ASSERT_NEXT(a_enter, clk, rst_n, req.valid && req.ready, sh_valid)

endmodule
